@@ design/pmrp_pkg.sv @@
// ----------------------------------------------------------------------------
// pmrp_pkg: shared types and constants of the passive-mode reply parser
// Character codes, limits, tracker phase encoding and tracker state record.
// ----------------------------------------------------------------------------
package pmrp_pkg;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_OPEN  = 8'h28;
	localparam logic [7:0] CHR_CLOSE = 8'h29;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	localparam logic [2:0] NUM_COUNT = 3'd6;
	localparam logic [8:0] NUM_MAX   = 9'd255;
	localparam logic [8:0] ACC_SAT   = 9'd256;
	localparam logic [1:0] POS_START = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SKIP = 2'd1,
		PH_NUM  = 2'd2,
		PH_STOP = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t          phase;
		logic [2:0]      count;
		logic [8:0]      acc;
		logic [5:0][7:0] nums;
		logic            viol;
	} tracker_t;

	localparam tracker_t TRACKER_RESET = '{
		phase: PH_IDLE, count: 3'd0, acc: 9'd0, nums: '0, viol: 1'b0
	};

endpackage

@@ design/pmrp_line_if.sv @@
// ----------------------------------------------------------------------------
// pmrp_line_if: byte channel of the reply line
// One character per transfer, with a flag on the last character of a line.
// ----------------------------------------------------------------------------
interface pmrp_line_if;

	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       final_byte;

	modport source (output valid, output line_byte, output final_byte, input ready);
	modport sink (input valid, input line_byte, input final_byte, output ready);

endinterface

@@ design/pmrp_reply_if.sv @@
// ----------------------------------------------------------------------------
// pmrp_reply_if: result channel of the reply parser
// One transfer per line: accept flag, host address octets and port.
// ----------------------------------------------------------------------------
interface pmrp_reply_if;

	logic        valid;
	logic        ready;
	logic        accepted;
	logic [7:0]  octet_a;
	logic [7:0]  octet_b;
	logic [7:0]  octet_c;
	logic [7:0]  octet_d;
	logic [15:0] port_number;

	modport source (
		output valid, output accepted, output octet_a, output octet_b,
		output octet_c, output octet_d, output port_number, input ready
	);
	modport sink (
		input valid, input accepted, input octet_a, input octet_b,
		input octet_c, input octet_d, input port_number, output ready
	);

endinterface

@@ design/passive_mode_reply_parser_unit.sv @@
// ----------------------------------------------------------------------------
// passive_mode_reply_parser_unit: FTP passive-mode reply parser
// The line channel delivers a reply line one character per transfer; the
// transfer that carries final_byte = 1 closes the line. For each line one
// transfer on the reply channel reports whether six numbers in 0..255 were
// found, the four address octets and the port (fifth * 256 + sixth).
// Numbers are taken after the first '(' of the line or, if there is none,
// from the fourth character on. A zero character ends the line text early.
// Rate: one character per cycle, sustained while no final character waits for
// a busy result register. A character is held in an input register, then the
// parse state is updated by a single pass of compare and multiply-by-ten
// logic; the final character loads the result register, from which the reply
// is offered on the reply channel.
// A stalled reply holds only a following final character in the input
// register; other characters keep flowing. After reset the block is empty
// and ready, and every line starts from a clean parse state.
// ----------------------------------------------------------------------------
module passive_mode_reply_parser_unit
	import pmrp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	pmrp_line_if.sink           line,
	pmrp_reply_if.source        reply
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// Parse state of the current line.
	logic [1:0]    pos_q;
	logic          bracket_q;
	logic          text_ended_q;
	tracker_t [1:0] trk_q;

	// Result register.
	logic        reply_valid_q;
	logic        accepted_q;
	logic [7:0]  octet_a_q;
	logic [7:0]  octet_b_q;
	logic [7:0]  octet_c_q;
	logic [7:0]  octet_d_q;
	logic [15:0] port_q;

	logic           advance;
	logic           in_accept;
	logic [1:0]     pos_nx;
	logic           bracket_nx;
	logic           text_ended_nx;
	tracker_t [1:0] trk_nx;
	tracker_t       sel;
	logic           ok;

	function automatic tracker_t store_number(tracker_t t);
		tracker_t r;
		r = t;
		if (t.count < NUM_COUNT) begin
			r.nums[t.count] = (t.acc > NUM_MAX) ? NUM_MAX[7:0] : t.acc[7:0];
			if (t.acc > NUM_MAX) begin
				r.viol = 1'b1;
			end
			r.count = t.count + 3'd1;
		end
		r.acc = '0;
		return r;
	endfunction

	function automatic tracker_t tracker_byte(tracker_t t, logic [7:0] b);
		tracker_t    r;
		logic        numeral;
		logic [3:0]  d;
		logic [11:0] prod;
		logic        done;
		r        = t;
		numeral  = (b >= CHR_ZERO) && (b <= CHR_NINE);
		d        = 4'(b - CHR_ZERO);
		prod     = 12'(t.acc) * 12'd10 + 12'(d);
		done     = 1'b0;
		if (t.phase == PH_SKIP || t.phase == PH_NUM) begin
			if (numeral) begin
				if (t.phase == PH_SKIP) begin
					r.acc   = 9'(d);
					r.phase = PH_NUM;
				end else begin
					r.acc = (prod > 12'(ACC_SAT)) ? ACC_SAT : prod[8:0];
				end
			end else begin
				if (t.phase == PH_NUM) begin
					r = store_number(r);
					if (r.count >= NUM_COUNT) begin
						r.phase = PH_STOP;
						done    = 1'b1;
					end else begin
						r.phase = PH_SKIP;
					end
				end
				if (!done && (b == CHR_CLOSE || b == CHR_CR || b == CHR_LF)) begin
					r.phase = PH_STOP;
				end
			end
		end
		return r;
	endfunction

	function automatic tracker_t tracker_end(tracker_t t);
		tracker_t r;
		r = t;
		if (t.phase == PH_NUM) begin
			r = store_number(r);
		end
		if (t.phase != PH_IDLE) begin
			r.phase = PH_STOP;
		end
		return r;
	endfunction

	// A final character may only move on when the result register is free.
	assign advance    = valid_s1 && (!final_s1 || !reply_valid_q || reply.ready);
	assign line.ready = !valid_s1 || advance;
	assign in_accept  = line.valid && line.ready;

	always_comb begin
		pos_nx        = pos_q;
		bracket_nx    = bracket_q;
		text_ended_nx = text_ended_q;
		trk_nx        = trk_q;
		if (!text_ended_q) begin
			if (byte_s1 == CHR_NUL) begin
				trk_nx[0]     = tracker_end(trk_q[0]);
				trk_nx[1]     = tracker_end(trk_q[1]);
				text_ended_nx = 1'b1;
			end else begin
				if (pos_q == POS_START && trk_q[1].phase == PH_IDLE) begin
					trk_nx[1].phase = PH_SKIP;
				end
				trk_nx[0] = tracker_byte(trk_nx[0], byte_s1);
				trk_nx[1] = tracker_byte(trk_nx[1], byte_s1);
				if (byte_s1 == CHR_OPEN && !bracket_q) begin
					bracket_nx = 1'b1;
					if (trk_nx[0].phase == PH_IDLE) begin
						trk_nx[0].phase = PH_SKIP;
					end
				end
				if (pos_q != POS_START) begin
					pos_nx = pos_q + 2'd1;
				end
			end
		end
		// Closing the line completes any number still in progress.
		sel = bracket_nx ? tracker_end(trk_nx[0]) : tracker_end(trk_nx[1]);
		ok  = (sel.count == NUM_COUNT) && !sel.viol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= line.line_byte;
			final_s1 <= line.final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			bracket_q    <= 1'b0;
			text_ended_q <= 1'b0;
			trk_q        <= {TRACKER_RESET, TRACKER_RESET};
		end else if (advance) begin
			if (final_s1) begin
				pos_q        <= '0;
				bracket_q    <= 1'b0;
				text_ended_q <= 1'b0;
				trk_q        <= {TRACKER_RESET, TRACKER_RESET};
			end else begin
				pos_q        <= pos_nx;
				bracket_q    <= bracket_nx;
				text_ended_q <= text_ended_nx;
				trk_q        <= trk_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			reply_valid_q <= 1'b1;
		end else if (reply.ready) begin
			reply_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			accepted_q <= ok;
			octet_a_q  <= ok ? sel.nums[0] : 8'd0;
			octet_b_q  <= ok ? sel.nums[1] : 8'd0;
			octet_c_q  <= ok ? sel.nums[2] : 8'd0;
			octet_d_q  <= ok ? sel.nums[3] : 8'd0;
			port_q     <= ok ? {sel.nums[4], sel.nums[5]} : 16'd0;
		end
	end

	assign reply.valid       = reply_valid_q;
	assign reply.accepted    = accepted_q;
	assign reply.octet_a     = octet_a_q;
	assign reply.octet_b     = octet_b_q;
	assign reply.octet_c     = octet_c_q;
	assign reply.octet_d     = octet_d_q;
	assign reply.port_number = port_q;

	// A rejected line reports all-zero address and port.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid_q && !accepted_q |->
			octet_a_q == 8'd0 && octet_b_q == 8'd0 && octet_c_q == 8'd0 &&
			octet_d_q == 8'd0 && port_q == 16'd0)
		else $error("rejected reply carries nonzero fields");

	// Closing a line leaves a clean parse state for the next one.
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && final_s1 |=>
			pos_q == 2'd0 && !bracket_q && !text_ended_q &&
			trk_q[0].phase == PH_IDLE && trk_q[1].phase == PH_IDLE &&
			trk_q[0].count == 3'd0 && trk_q[1].count == 3'd0)
		else $error("parse state not cleared after final character");

	// Neither tracker collects more than six numbers.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		trk_q[0].count <= NUM_COUNT && trk_q[1].count <= NUM_COUNT)
		else $error("tracker number count out of range");

	// The line channel stalls only behind a final character waiting for the result slot.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!line.ready |-> valid_s1 && final_s1 && reply_valid_q && !reply.ready)
		else $error("line channel stalled without a blocked result");

endmodule

@@ dv/passive_mode_reply_parser_unit_test.sv @@
// ----------------------------------------------------------------------------
// passive_mode_reply_parser_unit_test: testbench of the passive-mode reply parser
// Reply lines go in one character per transfer. A parser model in the bench
// predicts the reply of every line, and each reply transfer is checked
// field by field. Directed lines come first, then random lines under
// several sender and receiver idling mixes and one long receiver hold.
// ----------------------------------------------------------------------------
module passive_mode_reply_parser_unit_test;
	import pmrp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} line_char_t;

	typedef struct {
		logic        accepted;
		logic [7:0]  octet_a;
		logic [7:0]  octet_b;
		logic [7:0]  octet_c;
		logic [7:0]  octet_d;
		logic [15:0] port_number;
	} pasv_reply_t;

	logic clk;
	logic arst_n;

	pmrp_line_if  line_ch ();
	pmrp_reply_if reply_ch ();

	passive_mode_reply_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.reply  (reply_ch)
	);

	line_char_t  pending_chars [$];
	pasv_reply_t expected_replies [$];
	logic [7:0]  line_buf [$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int errors = 0;
	logic char_taken = 1'b0;

	// Parser state of the line in flight.
	tracker_t   trk [2] = '{TRACKER_RESET, TRACKER_RESET};
	logic [1:0] chars_seen = '0;
	logic       paren_seen = 1'b0;
	logic       text_over = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	function automatic logic is_numeral(input logic [7:0] c);
		return c >= CHR_ZERO && c <= CHR_NINE;
	endfunction

	task automatic bank_number(input int t);
		if (trk[t].count < NUM_COUNT) begin
			trk[t].nums[trk[t].count] = (trk[t].acc > NUM_MAX) ? NUM_MAX[7:0] : trk[t].acc[7:0];
			if (trk[t].acc > NUM_MAX)
				trk[t].viol = 1'b1;
			trk[t].count = trk[t].count + 3'd1;
		end
		trk[t].acc = '0;
	endtask

	task automatic step_tracker(input int t, input logic [7:0] c);
		int v;
		if (trk[t].phase != PH_SKIP && trk[t].phase != PH_NUM)
			return;
		if (is_numeral(c)) begin
			if (trk[t].phase == PH_SKIP) begin
				trk[t].acc = 9'(c - CHR_ZERO);
				trk[t].phase = PH_NUM;
			end else begin
				v = int'(trk[t].acc) * 10 + int'(c - CHR_ZERO);
				trk[t].acc = (v > int'(ACC_SAT)) ? ACC_SAT : 9'(v);
			end
			return;
		end
		if (trk[t].phase == PH_NUM) begin
			bank_number(t);
			if (trk[t].count >= NUM_COUNT) begin
				trk[t].phase = PH_STOP;
				return;
			end
			trk[t].phase = PH_SKIP;
		end
		if (c == CHR_CLOSE || c == CHR_CR || c == CHR_LF)
			trk[t].phase = PH_STOP;
	endtask

	task automatic close_tracker(input int t);
		if (trk[t].phase == PH_NUM)
			bank_number(t);
		if (trk[t].phase != PH_IDLE)
			trk[t].phase = PH_STOP;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic fin);
		pasv_reply_t r;
		int t;
		if (!text_over) begin
			if (c == CHR_NUL) begin
				close_tracker(0);
				close_tracker(1);
				text_over = 1'b1;
			end else begin
				if (chars_seen == POS_START && trk[1].phase == PH_IDLE)
					trk[1].phase = PH_SKIP;
				step_tracker(0, c);
				step_tracker(1, c);
				if (c == CHR_OPEN && !paren_seen) begin
					paren_seen = 1'b1;
					if (trk[0].phase == PH_IDLE)
						trk[0].phase = PH_SKIP;
				end
				if (chars_seen < POS_START)
					chars_seen = chars_seen + 2'd1;
			end
		end
		if (fin) begin
			close_tracker(0);
			close_tracker(1);
			// The offset tracker counts only when the line has no opening bracket.
			t = paren_seen ? 0 : 1;
			r = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0};
			if (trk[t].count == NUM_COUNT && !trk[t].viol) begin
				r.accepted = 1'b1;
				r.octet_a = trk[t].nums[0];
				r.octet_b = trk[t].nums[1];
				r.octet_c = trk[t].nums[2];
				r.octet_d = trk[t].nums[3];
				r.port_number = {trk[t].nums[4], trk[t].nums[5]};
			end
			expected_replies.push_back(r);
			trk[0] = TRACKER_RESET;
			trk[1] = TRACKER_RESET;
			chars_seen = '0;
			paren_seen = 1'b0;
			text_over = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Line side: driver and transfer monitor
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		line_char_t nxt;
		if (!arst_n) begin
			line_ch.valid <= 1'b0;
		end else if (!line_ch.valid || char_taken) begin
			if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				nxt = pending_chars.pop_front();
				line_ch.valid <= 1'b1;
				line_ch.line_byte <= nxt.value;
				line_ch.final_byte <= nxt.last;
			end else begin
				line_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_taken <= 1'b0;
		end else begin
			char_taken <= line_ch.valid && line_ch.ready;
			if (line_ch.valid && line_ch.ready)
				parse_char(line_ch.line_byte, line_ch.final_byte);
		end
	end

	// ------------------------------------------------------------------
	// Reply side: receiver and checker
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (holds_served < hold_requests) begin
			holds_served++;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			reply_ch.ready <= 1'b0;
		end else begin
			reply_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		pasv_reply_t want;
		if (arst_n && reply_ch.valid && reply_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: reply transfer with no line pending, expected none, actual %0d",
					$time, reply_ch.accepted);
				errors++;
			end else begin
				want = expected_replies.pop_front();
				check_field("accepted", want.accepted, reply_ch.accepted);
				check_field("octet_a", want.octet_a, reply_ch.octet_a);
				check_field("octet_b", want.octet_b, reply_ch.octet_b);
				check_field("octet_c", want.octet_c, reply_ch.octet_c);
				check_field("octet_d", want.octet_d, reply_ch.octet_d);
				check_field("port_number", want.port_number, reply_ch.port_number);
			end
		end
	end

	// ------------------------------------------------------------------
	// Line building
	// ------------------------------------------------------------------
	task automatic put_text(input string s);
		foreach (s[i])
			line_buf.push_back(s[i]);
	endtask

	// Queues the buffered line; returns its length.
	task automatic commit_line(output int len);
		len = line_buf.size();
		foreach (line_buf[i])
			pending_chars.push_back('{line_buf[i], i == line_buf.size() - 1});
		line_buf.delete();
	endtask

	task automatic put_number();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			repeat ($urandom_range(1, 3)) put_text("0");
		if (pick < 65)
			put_text($sformatf("%0d", $urandom_range(0, 255)));
		else if (pick < 80)
			put_text($urandom_range(1) ? "255" : "0");
		else if (pick < 92)
			put_text($sformatf("%0d", $urandom_range(256, 999)));
		else
			repeat ($urandom_range(4, 8)) line_buf.push_back(CHR_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic make_random_line(output int len);
		int kind;
		int count;
		int pos;
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
		end else if (kind < 14) begin
			repeat ($urandom_range(1, 4))
				case ($urandom_range(3))
					0: line_buf.push_back(CHR_OPEN);
					1: line_buf.push_back(CHR_ZERO + 8'($urandom_range(9)));
					2: line_buf.push_back(CHR_CLOSE);
					default: line_buf.push_back(8'($urandom));
				endcase
		end else begin
			case ($urandom_range(5))
				0: put_text("227 Entering Passive Mode ");
				1: repeat ($urandom_range(0, 5)) line_buf.push_back(8'($urandom_range(32, 126)));
				2: put_text("227 =");
				default: put_text("227 ");
			endcase
			if (kind < 82)
				put_text("(");
			count = ($urandom_range(99) < 85) ? 6 : $urandom_range(0, 9);
			for (int i = 0; i < count; i++) begin
				put_number();
				if (i != count - 1)
					case ($urandom_range(9))
						0: put_text(" ");
						1: put_text(", ");
						2: line_buf.push_back($urandom_range(1) ? CHR_CR : CHR_LF);
						3: if ($urandom_range(3) == 0) line_buf.push_back(CHR_CLOSE);
							else put_text(",");
						default: put_text(",");
					endcase
			end
			if ($urandom_range(3) != 0)
				line_buf.push_back(CHR_CLOSE);
			if ($urandom_range(1))
				put_text(".");
			if ($urandom_range(2) == 0) begin
				line_buf.push_back(CHR_CR);
				line_buf.push_back(CHR_LF);
			end
			// A zero character somewhere cuts the line text short.
			if ($urandom_range(99) < 6) begin
				pos = $urandom_range(0, line_buf.size() - 1);
				line_buf[pos] = CHR_NUL;
			end
		end
		commit_line(len);
	endtask

	task automatic send_random_lines(input int budget);
		int queued;
		int len;
		queued = 0;
		while (queued < budget) begin
			make_random_line(len);
			queued += len;
		end
	endtask

	task automatic send_text_line(input string s);
		int len;
		put_text(s);
		commit_line(len);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_chars.size() != 0 || line_ch.valid || expected_replies.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int len;
		arst_n = 1'b0;
		line_ch.valid = 1'b0;
		line_ch.line_byte = 8'd0;
		line_ch.final_byte = 1'b0;
		reply_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		put_text("227 Entering Passive Mode (192,168,1,2,19,137).");
		line_buf.push_back(CHR_CR);
		line_buf.push_back(CHR_LF);
		commit_line(len);
		send_text_line("(255,255,255,255,255,255)");
		send_text_line("(0,0,0,0,0,0)");
		send_text_line("(1,2,3,4,256,7)");
		send_text_line("227 10,0,0,1,4,1");
		send_text_line("ab");
		send_text_line("7");
		// Zero character inside a number, then inside a bracket-less line.
		put_text("227 (10,2");
		line_buf.push_back(CHR_NUL);
		put_text("0,3,4,5,6)");
		commit_line(len);
		put_text("227 1,2,3,4,5,6");
		line_buf.push_back(CHR_NUL);
		put_text("(9,9,9,9,9,9)");
		commit_line(len);
		line_buf.push_back(CHR_NUL);
		commit_line(len);
		send_text_line("(1,2,3,4,5,6");
		send_text_line("(1,2,3,4,5,6,7,8)");
		send_text_line("(1,2)3,4,5,6)");
		put_text("(1,2,");
		line_buf.push_back(CHR_CR);
		put_text("3,4,5,6)");
		commit_line(len);
		put_text("(1,2,3");
		line_buf.push_back(CHR_LF);
		put_text(",4,5,6)");
		commit_line(len);
		send_text_line("x(0009,00255,1,1,99999,65)");
		send_text_line("((1,2,3,4,5,6)");
		send_text_line("123(");
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		put_text("(8,8,8,8,255,0)");
		line_buf.push_back(8'h7F);
		commit_line(len);
		wait_drained();

		send_random_lines(200);
		wait_drained();

		sender_idle_pct = 51;
		send_random_lines(200);
		wait_drained();

		sender_idle_pct = 0;
		receiver_stall_pct = 51;
		send_random_lines(200);
		wait_drained();

		sender_idle_pct = 8;
		receiver_stall_pct = 8;
		send_random_lines(200);
		wait_drained();

		// Long receiver hold while lines keep coming, so the input backs up.
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_random_lines(120);
		hold_requests++;
		wait_drained();

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ passive_mode_reply_parser_unit.f @@
design/pmrp_pkg.sv
design/pmrp_line_if.sv
design/pmrp_reply_if.sv
design/passive_mode_reply_parser_unit.sv
dv/passive_mode_reply_parser_unit_test.sv
